/* src/huffman_tree_encoder_macros.svh */
// assertion macros used by the checker file hte_checker
`ifndef HUFFMAN_TREE_ENCODER_MACROS_SVH
`define HUFFMAN_TREE_ENCODER_MACROS_SVH

// checked only outside reset
`define HTE_CHECK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("hte port check failed");

// checked in every cycle, reset included
`define HTE_CHECK_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("hte port check failed");

`endif

/* src/hte_pkg.sv */
// ----------------------------------------------------------------------------
// hte_pkg
// Types and constants shared by the huffman encoder front and back ends.
// ----------------------------------------------------------------------------
package hte_pkg;

   localparam int CNT_W  = 16;
   localparam int LEN_W  = 5;
   localparam int BYTE_W = 8;

   localparam logic [1:0] OP_COUNT  = 2'd0;
   localparam logic [1:0] OP_ENCODE = 2'd1;
   localparam logic [1:0] OP_FLUSH  = 2'd2;

   typedef enum logic [1:0] {
      CMD_COUNT,
      CMD_ENCODE,
      CMD_FLUSH
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [BYTE_W-1:0] sym;
      logic              in_range;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CNT_WR,
      ST_INIT_RD,
      ST_INIT_WR,
      ST_SCAN,
      ST_MRG_NEW,
      ST_MRG_A,
      ST_MRG_B,
      ST_GEN_RD,
      ST_GEN_CHK,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_ENC_RD,
      ST_ENC_CHK,
      ST_EMIT
   } back_state_type;

endpackage

/* src/hte_front.sv */
// ----------------------------------------------------------------------------
// hte_front
// Takes request transactions, decodes the op and queues the commands.
// ----------------------------------------------------------------------------
module hte_front import hte_pkg::*; #(
   parameter int SYMBOLS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_op,
   input  logic [BYTE_W-1:0] req_symbol,
   input  logic              pop,
   output logic              head_valid,
   output cmd_type           head
);

   cmd_type    q_ff [2];
   cmd_type    q_in [2];
   logic [1:0] q_cnt_ff;
   logic [1:0] q_cnt_in;
   cmd_type    new_cmd;
   logic       op_ok;
   logic       push;

   assign busy       = (q_cnt_ff == 2'd2);
   assign head_valid = (q_cnt_ff != 2'd0);
   assign head       = q_ff[0];

   always_comb begin
      new_cmd.sym      = req_symbol;
      new_cmd.in_range = ({1'b0, req_symbol} < 9'(SYMBOLS));
      op_ok            = 1'b1;
      unique case (req_op)
         OP_COUNT:  new_cmd.kind = CMD_COUNT;
         OP_ENCODE: new_cmd.kind = CMD_ENCODE;
         OP_FLUSH:  new_cmd.kind = CMD_FLUSH;
         default: begin
            // unknown op is dropped here
            new_cmd.kind = CMD_COUNT;
            op_ok        = 1'b0;
         end
      endcase
   end

   assign push = start && !busy && op_ok;

   always_comb begin
      q_in     = q_ff;
      q_cnt_in = q_cnt_ff;
      if (pop && head_valid) begin
         q_in[0]  = q_ff[1];
         q_cnt_in = q_cnt_ff - 2'd1;
      end
      if (push) begin
         q_in[q_cnt_in[0]] = new_cmd;
         q_cnt_in          = q_cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_cnt_ff <= 2'd0;
      end else begin
         q_cnt_ff <= q_cnt_in;
      end
      q_ff <= q_in;
   end

endmodule

/* src/hte_back.sv */
// ----------------------------------------------------------------------------
// hte_back
// Executes queued commands: histogram update, tree build, code table walk,
// bit packing and flush.
// ----------------------------------------------------------------------------
module hte_back import hte_pkg::*; #(
   parameter int SYMBOLS      = 256,
   parameter int COUNT_MAX    = 65535,
   parameter int MAX_CODE_LEN = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  cmd_type           head,
   output logic              pop,
   output logic              rsp_strobe,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_has_byte,
   output logic              rsp_bad_symbol,
   output logic              rsp_run_last
);

   localparam int NODES  = 2 * SYMBOLS - 1;
   localparam int SYM_W  = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
   localparam int NODE_W = $clog2(NODES);
   localparam int ACC_W  = MAX_CODE_LEN + 7;
   localparam int N_W    = $clog2(ACC_W + 1);
   localparam int CODE_W = LEN_W + MAX_CODE_LEN;
   localparam logic [SYM_W-1:0]  LAST_SYM  = SYM_W'(SYMBOLS - 1);
   localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);

   // memories
   logic [CNT_W-1:0]  hist_mem [SYMBOLS];
   logic [CNT_W:0]    node_mem [NODES];
   logic [NODE_W:0]   link_mem [NODES];
   logic [CODE_W-1:0] code_mem [SYMBOLS];

   logic              hist_we;
   logic [SYM_W-1:0]  hist_waddr, hist_raddr;
   logic [CNT_W-1:0]  hist_wdata, hist_rdata_ff;
   logic              node_we;
   logic [NODE_W-1:0] node_waddr, node_raddr;
   logic [CNT_W:0]    node_wdata, node_rdata_ff;
   logic              link_we;
   logic [NODE_W-1:0] link_waddr;
   logic [NODE_W:0]   link_wdata, link_rdata_ff;
   logic              code_we;
   logic [SYM_W-1:0]  code_waddr, code_raddr;
   logic [CODE_W-1:0] code_wdata, code_rdata_ff;

   logic [SYMBOLS-1:0] hist_vld_ff;
   logic               hist_set, hist_clr;
   logic               hist_rvld_ff;

   back_state_type     state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic               tree_ready_ff, tree_ready_in;
   logic [6:0]         pend_bits_ff, pend_bits_in;
   logic [2:0]         pend_cnt_ff, pend_cnt_in;
   logic [SYM_W-1:0]   sym_idx_ff, sym_idx_in;
   logic [1:0]         leaves_ff, leaves_in;
   logic [NODE_W-1:0]  used_ff, used_in;
   logic [NODE_W-1:0]  scan_idx_ff, scan_idx_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [NODE_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic               b1_vld_ff, b1_vld_in, b2_vld_ff, b2_vld_in;
   logic [NODE_W-1:0]  b1_idx_ff, b1_idx_in, b2_idx_ff, b2_idx_in;
   logic [CNT_W-1:0]   b1_w_ff, b1_w_in, b2_w_ff, b2_w_in;
   logic [NODE_W-1:0]  walk_n_ff, walk_n_in;
   logic [LEN_W-1:0]   walk_len_ff, walk_len_in;
   logic [MAX_CODE_LEN-1:0] walk_code_ff, walk_code_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [N_W-1:0]     n_ff, n_in;

   logic               strobe_in, has_in, bad_in, last_in;
   logic [BYTE_W-1:0]  byte_in;
   logic               strobe_ff, has_ff, bad_ff, last_ff;
   logic [BYTE_W-1:0]  byte_ff;

   logic [CNT_W-1:0]   hist_val;
   logic [CNT_W-1:0]   scan_w;
   logic               scan_free;
   logic [LEN_W-1:0]   code_len;
   logic [MAX_CODE_LEN-1:0] code_val;

   assign hist_val  = hist_rvld_ff ? hist_rdata_ff : '0;
   assign scan_w    = node_rdata_ff[CNT_W-1:0];
   assign scan_free = node_rdata_ff[CNT_W];
   assign code_len  = code_rdata_ff[CODE_W-1 -: LEN_W];
   assign code_val  = code_rdata_ff[MAX_CODE_LEN-1:0];

   assign hist_raddr = (state_ff == ST_IDLE) ? head.sym[SYM_W-1:0] : sym_idx_ff;
   assign node_raddr = (state_ff == ST_SCAN) ? scan_idx_ff : walk_n_ff;
   assign code_raddr = (state_ff == ST_IDLE) ? head.sym[SYM_W-1:0] : cmd_ff.sym[SYM_W-1:0];

   always_ff @(posedge clock) begin
      if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
      hist_rdata_ff <= hist_mem[hist_raddr];
      hist_rvld_ff  <= hist_vld_ff[hist_raddr];
      if (node_we) node_mem[node_waddr] <= node_wdata;
      node_rdata_ff <= node_mem[node_raddr];
      if (link_we) link_mem[link_waddr] <= link_wdata;
      link_rdata_ff <= link_mem[walk_n_ff];
      if (code_we) code_mem[code_waddr] <= code_wdata;
      code_rdata_ff <= code_mem[code_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset || hist_clr) begin
         hist_vld_ff <= '0;
      end else if (hist_set) begin
         hist_vld_ff[hist_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         total_ff      <= '0;
         tree_ready_ff <= 1'b0;
         pend_bits_ff  <= '0;
         pend_cnt_ff   <= '0;
         strobe_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         total_ff      <= total_in;
         tree_ready_ff <= tree_ready_in;
         pend_bits_ff  <= pend_bits_in;
         pend_cnt_ff   <= pend_cnt_in;
         strobe_ff     <= strobe_in;
      end
      cmd_ff       <= cmd_in;
      sym_idx_ff   <= sym_idx_in;
      leaves_ff    <= leaves_in;
      used_ff      <= used_in;
      scan_idx_ff  <= scan_idx_in;
      cmp_vld_ff   <= cmp_vld_in;
      cmp_idx_ff   <= cmp_idx_in;
      b1_vld_ff    <= b1_vld_in;
      b1_idx_ff    <= b1_idx_in;
      b1_w_ff      <= b1_w_in;
      b2_vld_ff    <= b2_vld_in;
      b2_idx_ff    <= b2_idx_in;
      b2_w_ff      <= b2_w_in;
      walk_n_ff    <= walk_n_in;
      walk_len_ff  <= walk_len_in;
      walk_code_ff <= walk_code_in;
      acc_ff       <= acc_in;
      n_ff         <= n_in;
      byte_ff      <= byte_in;
      has_ff       <= has_in;
      bad_ff       <= bad_in;
      last_ff      <= last_in;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      total_in      = total_ff;
      tree_ready_in = tree_ready_ff;
      pend_bits_in  = pend_bits_ff;
      pend_cnt_in   = pend_cnt_ff;
      sym_idx_in    = sym_idx_ff;
      leaves_in     = leaves_ff;
      used_in       = used_ff;
      scan_idx_in   = scan_idx_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = scan_idx_ff;
      b1_vld_in     = b1_vld_ff;
      b1_idx_in     = b1_idx_ff;
      b1_w_in       = b1_w_ff;
      b2_vld_in     = b2_vld_ff;
      b2_idx_in     = b2_idx_ff;
      b2_w_in       = b2_w_ff;
      walk_n_in     = walk_n_ff;
      walk_len_in   = walk_len_ff;
      walk_code_in  = walk_code_ff;
      acc_in        = acc_ff;
      n_in          = n_ff;
      strobe_in     = 1'b0;
      byte_in       = '0;
      has_in        = 1'b0;
      bad_in        = 1'b0;
      last_in       = 1'b0;
      pop           = 1'b0;
      hist_we       = 1'b0;
      hist_set      = 1'b0;
      hist_clr      = 1'b0;
      hist_waddr    = cmd_ff.sym[SYM_W-1:0];
      hist_wdata    = hist_val + CNT_W'(1);
      node_we       = 1'b0;
      node_waddr    = used_ff;
      node_wdata    = {1'b1, CNT_W'(b1_w_ff + b2_w_ff)};
      link_we       = 1'b0;
      link_waddr    = b1_idx_ff;
      link_wdata    = {used_ff, 1'b0};
      code_we       = 1'b0;
      code_waddr    = sym_idx_ff;
      code_wdata    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop    = 1'b1;
               cmd_in = head;
               unique case (head.kind)
                  CMD_COUNT: begin
                     if (!tree_ready_ff && head.in_range &&
                         (total_ff < CNT_W'(COUNT_MAX))) begin
                        state_in = ST_CNT_WR;
                     end
                  end
                  CMD_ENCODE: begin
                     if (tree_ready_ff) begin
                        state_in = ST_ENC_CHK;
                     end else begin
                        sym_idx_in = '0;
                        leaves_in  = 2'd0;
                        state_in   = ST_INIT_RD;
                     end
                  end
                  CMD_FLUSH: begin
                     if (pend_cnt_ff != 3'd0) begin
                        strobe_in = 1'b1;
                        has_in    = 1'b1;
                        last_in   = 1'b1;
                        byte_in   = BYTE_W'({1'b0, pend_bits_ff} << (4'd8 - {1'b0, pend_cnt_ff}));
                     end
                     hist_clr      = 1'b1;
                     total_in      = '0;
                     tree_ready_in = 1'b0;
                     pend_bits_in  = '0;
                     pend_cnt_in   = '0;
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end

         ST_CNT_WR: begin
            hist_we  = 1'b1;
            hist_set = 1'b1;
            total_in = total_ff + CNT_W'(1);
            state_in = ST_IDLE;
         end

         ST_INIT_RD: begin
            state_in = ST_INIT_WR;
         end

         ST_INIT_WR: begin
            node_we    = 1'b1;
            node_waddr = NODE_W'(sym_idx_ff);
            node_wdata = {(hist_val != '0), hist_val};
            if ((hist_val != '0) && (leaves_ff != 2'd2)) begin
               leaves_in = leaves_ff + 2'd1;
            end
            if (sym_idx_ff == LAST_SYM) begin
               if (leaves_in == 2'd1) begin
                  sym_idx_in = '0;
                  walk_n_in  = '0;
                  state_in   = ST_GEN_RD;
               end else begin
                  used_in     = NODE_W'(SYMBOLS);
                  scan_idx_in = '0;
                  b1_vld_in   = 1'b0;
                  b2_vld_in   = 1'b0;
                  state_in    = ST_SCAN;
               end
            end else begin
               sym_idx_in = sym_idx_ff + SYM_W'(1);
               state_in   = ST_INIT_RD;
            end
         end

         ST_SCAN: begin
            // pipelined pass keeping the two lightest free nodes, lower index on a tie
            if (cmp_vld_ff && scan_free) begin
               if (!b1_vld_ff || (scan_w < b1_w_ff)) begin
                  b2_vld_in = b1_vld_ff;
                  b2_idx_in = b1_idx_ff;
                  b2_w_in   = b1_w_ff;
                  b1_vld_in = 1'b1;
                  b1_idx_in = cmp_idx_ff;
                  b1_w_in   = scan_w;
               end else if (!b2_vld_ff || (scan_w < b2_w_ff)) begin
                  b2_vld_in = 1'b1;
                  b2_idx_in = cmp_idx_ff;
                  b2_w_in   = scan_w;
               end
            end
            if (scan_idx_ff != used_ff) begin
               cmp_vld_in  = 1'b1;
               scan_idx_in = scan_idx_ff + NODE_W'(1);
            end else if (!cmp_vld_ff) begin
               if (b1_vld_ff && b2_vld_ff) begin
                  state_in = ST_MRG_NEW;
               end else begin
                  sym_idx_in = '0;
                  walk_n_in  = '0;
                  state_in   = ST_GEN_RD;
               end
            end
         end

         ST_MRG_NEW: begin
            node_we  = 1'b1;
            state_in = ST_MRG_A;
         end

         ST_MRG_A: begin
            node_we    = 1'b1;
            node_waddr = b1_idx_ff;
            node_wdata = {1'b0, b1_w_ff};
            link_we    = 1'b1;
            state_in   = ST_MRG_B;
         end

         ST_MRG_B: begin
            node_we    = 1'b1;
            node_waddr = b2_idx_ff;
            node_wdata = {1'b0, b2_w_ff};
            link_we    = 1'b1;
            link_waddr = b2_idx_ff;
            link_wdata = {used_ff, 1'b1};
            if (used_ff == LAST_NODE) begin
               sym_idx_in = '0;
               walk_n_in  = '0;
               state_in   = ST_GEN_RD;
            end else begin
               used_in     = used_ff + NODE_W'(1);
               scan_idx_in = '0;
               b1_vld_in   = 1'b0;
               b2_vld_in   = 1'b0;
               state_in    = ST_SCAN;
            end
         end

         ST_GEN_RD: begin
            state_in = ST_GEN_CHK;
         end

         ST_GEN_CHK: begin
            walk_len_in  = '0;
            walk_code_in = '0;
            if (hist_val == '0) begin
               code_we = 1'b1;
            end else if (leaves_ff == 2'd1) begin
               // lone symbol gets the single bit code 0
               code_we    = 1'b1;
               code_wdata = {LEN_W'(1), MAX_CODE_LEN'(0)};
            end else begin
               state_in = ST_WALK_CHK;
            end
         end

         ST_WALK_RD: begin
            state_in = ST_WALK_CHK;
         end

         ST_WALK_CHK: begin
            if (scan_free) begin
               code_we = 1'b1;
               if (walk_len_ff != '0) begin
                  code_wdata = {walk_len_ff, walk_code_ff};
               end
            end else if (walk_len_ff >= LEN_W'(MAX_CODE_LEN)) begin
               code_we = 1'b1;
            end else begin
               for (int k = 0; k < MAX_CODE_LEN; k++) begin
                  if (LEN_W'(k) == walk_len_ff) walk_code_in[k] = link_rdata_ff[0];
               end
               walk_len_in = walk_len_ff + LEN_W'(1);
               walk_n_in   = link_rdata_ff[NODE_W:1];
               state_in    = ST_WALK_RD;
            end
         end

         ST_ENC_RD: begin
            state_in = ST_ENC_CHK;
         end

         ST_ENC_CHK: begin
            if (!cmd_ff.in_range || (code_len == '0)) begin
               strobe_in = 1'b1;
               bad_in    = 1'b1;
               last_in   = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               acc_in   = (ACC_W'(pend_bits_ff) << code_len) | ACC_W'(code_val);
               n_in     = N_W'(pend_cnt_ff) + N_W'(code_len);
               state_in = ST_EMIT;
            end
         end

         ST_EMIT: begin
            if (n_ff >= N_W'(8)) begin
               strobe_in = 1'b1;
               has_in    = 1'b1;
               byte_in   = BYTE_W'(acc_ff >> (n_ff - N_W'(8)));
               last_in   = (n_ff < N_W'(16));
               n_in      = n_ff - N_W'(8);
            end else begin
               pend_bits_in = acc_ff[6:0] & ~(7'h7f << n_ff[2:0]);
               pend_cnt_in  = n_ff[2:0];
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // code table walk moves to the next symbol once an entry is written
      if (code_we) begin
         if (sym_idx_ff == LAST_SYM) begin
            tree_ready_in = 1'b1;
            state_in      = ST_ENC_RD;
         end else begin
            sym_idx_in = sym_idx_ff + SYM_W'(1);
            walk_n_in  = NODE_W'(sym_idx_ff) + NODE_W'(1);
            state_in   = ST_GEN_RD;
         end
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_has_byte   = has_ff;
   assign rsp_bad_symbol = bad_ff;
   assign rsp_run_last   = last_ff;

endmodule

/* src/huffman_tree_encoder.sv */
// ----------------------------------------------------------------------------
// huffman_tree_encoder
// Byte histogram, huffman tree build on first encode, and MSB-first packing.
//
//   channel  | handshake                 | payload
//   request  | start, busy               | req_op, req_symbol
//   response | rsp_strobe (one cycle)    | rsp_out_byte, rsp_has_byte,
//            |                           | rsp_bad_symbol, rsp_run_last
//
// count reads and then writes back its histogram entry; encode reads the code,
// then emits each whole byte. the first encode also builds the tree: a leaf
// load of every histogram entry, one scan of the node memory per merge, then
// a parent walk per code bit per symbol.
// a two entry command queue takes transactions while the back end works.
// reset is synchronous; histogram valid flags clear at once on reset and flush.
// ----------------------------------------------------------------------------
module huffman_tree_encoder import hte_pkg::*; #(
   parameter int SYMBOLS      = 256,
   parameter int COUNT_MAX    = 65535,
   parameter int MAX_CODE_LEN = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_op,
   input  logic [BYTE_W-1:0] req_symbol,
   output logic              rsp_strobe,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_has_byte,
   output logic              rsp_bad_symbol,
   output logic              rsp_run_last
);

   logic    pop;
   logic    head_valid;
   cmd_type head;

   hte_front #(
      .SYMBOLS (SYMBOLS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_op     (req_op),
      .req_symbol (req_symbol),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   hte_back #(
      .SYMBOLS      (SYMBOLS),
      .COUNT_MAX    (COUNT_MAX),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head           (head),
      .pop            (pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_has_byte   (rsp_has_byte),
      .rsp_bad_symbol (rsp_bad_symbol),
      .rsp_run_last   (rsp_run_last)
   );

endmodule

/* src/hte_checker.sv */
// ----------------------------------------------------------------------------
// hte_checker
// Port level checks on the encoder's response channel and busy output.
// ----------------------------------------------------------------------------
`include "huffman_tree_encoder_macros.svh"

module hte_checker import hte_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              busy,
   input logic              rsp_strobe,
   input logic [BYTE_W-1:0] rsp_out_byte,
   input logic              rsp_has_byte,
   input logic              rsp_bad_symbol,
   input logic              rsp_run_last
);

   `HTE_CHECK(a_bad_no_byte, rsp_strobe && rsp_bad_symbol |-> !rsp_has_byte && rsp_out_byte == 8'd0)
   `HTE_CHECK(a_bad_is_last, rsp_strobe && rsp_bad_symbol |-> rsp_run_last)
   `HTE_CHECK(a_kind_known, rsp_strobe |-> rsp_has_byte || rsp_bad_symbol)
   `HTE_CHECK_ALWAYS(a_reset_quiet, reset |=> !rsp_strobe && !busy)

endmodule

bind huffman_tree_encoder hte_checker u_hte_checker (
   .clock          (clock),
   .reset          (reset),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_has_byte   (rsp_has_byte),
   .rsp_bad_symbol (rsp_bad_symbol),
   .rsp_run_last   (rsp_run_last)
);
